[sv/dwd_pkg.sv]
package dwd_pkg;

   // Default number of entries held by the queue.
   localparam int DepthDefault = 32;

   // Fixed field widths of the request and response items.
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes carried by a request item.
   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_PUSH_BACK  = 3'd1;
   localparam op_type OP_VIEW_FWD   = 3'd2;
   localparam op_type OP_VIEW_BWD   = 3'd3;
   localparam op_type OP_DECIMATE   = 3'd4;
   localparam op_type OP_CLEAR      = 3'd5;

   // Status codes carried by a response item.
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_FEW   = 2'd3;

endpackage

[sv/dwd_req_if.sv]
interface dwd_req_if;

   logic                                valid;
   logic                                ready;
   dwd_pkg::op_type                     op;
   logic signed [dwd_pkg::DATA_W-1:0]   value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);

endinterface

[sv/dwd_rsp_if.sv]
interface dwd_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [dwd_pkg::DATA_W-1:0]   data;
   dwd_pkg::status_type                 status;
   logic                                last;
   logic [dwd_pkg::COUNT_W-1:0]         count;

   modport source (output valid, output data, output status, output last, output count,
                   input ready);
   modport sink   (input valid, input data, input status, input last, input count,
                   output ready);

endinterface

[sv/dwd_ram.sv]
module dwd_ram #(
   parameter int WIDTH = dwd_pkg::DATA_W,
   parameter int DEPTH = dwd_pkg::DepthDefault
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/deque_with_decimate_top.sv]
// Bounded double-ended queue of signed 32-bit values with decimation.
// Requests arrive on req_ch (op, value) and responses leave on rsp_ch
// (data, status, last, count); both use a valid/ready handshake and an
// item moves at a rising clock edge where valid and ready are both high.
// Push front, push back, clear and unused codes give one response item each
// and may follow one another in every cycle while the receiver takes the responses.
// A view gives one item per held entry (one item with empty status when
// nothing is held); after acceptance the first item passes the RAM read
// register and then the response register, and the rest follow one per
// cycle while the receiver takes them. A decimation of N entries writes
// ceil(N/2)-1 moved entries, one per cycle through the entry RAM, and then
// gives its one response item. The response sits in an output register, so
// a new request can be taken in the same cycle as the previous response is
// taken. Responses needing no view walk or move come in the cycle after acceptance.
// A stalled receiver holds the response register and the view walk in
// place; no request is taken until the current one has finished.
// Reset empties the queue and drops any response not yet taken; the entry
// RAM itself is not cleared, since entries are only read once written.
module deque_with_decimate_top #(
   parameter int DEPTH = dwd_pkg::DepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   dwd_req_if.sink     req_ch,
   dwd_rsp_if.source   rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 1;

   typedef enum logic [1:0] {S_IDLE, S_VIEW, S_DEC} state_type;

   state_type                         state_ff, state_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     kept_ff, kept_in;
   logic                              bwd_ff, bwd_in;
   logic                              out_valid_ff, out_valid_in;
   logic signed [dwd_pkg::DATA_W-1:0] out_data_ff, out_data_in;
   dwd_pkg::status_type               out_status_ff, out_status_in;
   logic                              out_last_ff, out_last_in;
   logic [dwd_pkg::COUNT_W-1:0]       out_count_ff, out_count_in;

   logic                              out_free;
   logic                              accept;
   logic                              full;
   logic [CW:0]                       kept_sum;
   logic [CW-1:0]                     kept_calc;
   logic                              out_load;
   logic signed [dwd_pkg::DATA_W-1:0] load_data;
   dwd_pkg::status_type               load_status;
   logic                              load_last;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic [dwd_pkg::DATA_W-1:0]        wr_data;
   logic [PW-1:0]                     rd_pos;
   logic [AW-1:0]                     rd_addr;
   logic [dwd_pkg::DATA_W-1:0]        rd_data;

   // Ring slot of a position counted from the front entry.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [PW-1:0] pos);
      logic [PW:0] sum;
      sum = {{(PW + 1 - AW){1'b0}}, head} + {1'b0, pos};
      if (sum >= (PW + 1)'(DEPTH)) begin
         sum = sum - (PW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Handshake and queue status.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff >= CW'(DEPTH));
   assign kept_sum     = {1'b0, count_ff} + (CW + 1)'(1);
   assign kept_calc    = kept_sum[CW:1];

   // Operation sequencing, RAM writes and response loading.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      bwd_in       = bwd_ff;
      out_load     = 1'b0;
      load_data    = '0;
      load_status  = dwd_pkg::ST_OK;
      load_last    = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_load = 1'b1;
               case (req_ch.op)
                  dwd_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        load_status = dwd_pkg::ST_FULL;
                     end else begin
                        head_in  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = head_in;
                        wr_data  = req_ch.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  dwd_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        load_status = dwd_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_of(head_ff, PW'(count_ff));
                        wr_data  = req_ch.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  dwd_pkg::OP_VIEW_FWD, dwd_pkg::OP_VIEW_BWD: begin
                     if (count_ff == '0) begin
                        load_status = dwd_pkg::ST_EMPTY;
                     end else begin
                        out_load = 1'b0;
                        state_in = S_VIEW;
                        idx_in   = '0;
                        bwd_in   = (req_ch.op == dwd_pkg::OP_VIEW_BWD);
                     end
                  end
                  dwd_pkg::OP_DECIMATE: begin
                     if (count_ff < CW'(2)) begin
                        load_status = dwd_pkg::ST_FEW;
                     end else if (kept_calc == CW'(1)) begin
                        count_in = kept_calc;
                     end else begin
                        out_load = 1'b0;
                        state_in = S_DEC;
                        idx_in   = CW'(1);
                        kept_in  = kept_calc;
                     end
                  end
                  dwd_pkg::OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     load_status = dwd_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_VIEW: begin
            // The RAM output holds the entry at view step idx_ff (from the front or the back) until it is taken.
            if (out_free) begin
               out_load  = 1'b1;
               load_data = rd_data;
               load_last = (idx_ff == count_ff - CW'(1));
               if (load_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         S_DEC: begin
            // The RAM output holds the entry at twice idx_ff; move it to idx_ff.
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, PW'(idx_ff));
            if (idx_ff == kept_ff - CW'(1)) begin
               count_in = kept_ff;
               out_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in  = out_load || (out_valid_ff && !rsp_ch.ready);
      out_data_in   = out_load ? load_data : out_data_ff;
      out_status_in = out_load ? load_status : out_status_ff;
      out_last_in   = out_load ? load_last : out_last_ff;
      out_count_in  = out_load ? dwd_pkg::COUNT_W'(count_in) : out_count_ff;
   end

   // Read address for the next cycle: the source entry of a move, or the
   // entry the view walk will hold.
   always_comb begin
      if (state_in == S_DEC) begin
         rd_pos = {idx_in, 1'b0};
      end else if (bwd_in) begin
         rd_pos = PW'(count_ff - CW'(1) - idx_in);
      end else begin
         rd_pos = PW'(idx_in);
      end
   end

   assign rd_addr = slot_of(head_ff, rd_pos);

   // State, pointers and response register.
   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
      idx_ff        <= idx_in;
      kept_ff       <= kept_in;
      bwd_ff        <= bwd_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Entry store.
   dwd_ram #(
      .WIDTH (dwd_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.data   = out_data_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.last   = out_last_ff;
   assign rsp_ch.count  = out_count_ff;

   // The queue never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // A clear empties the queue and rewinds the head.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == dwd_pkg::OP_CLEAR |=> count_ff == '0 && head_ff == '0)
      else $error("clear did not empty the queue");

   // An accepted push into a queue with room adds exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      accept && !full &&
      (req_ch.op == dwd_pkg::OP_PUSH_FRONT || req_ch.op == dwd_pkg::OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not add one entry");

   // A response that is not the final one can only come from a view walk.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_last_ff |-> state_ff == S_VIEW && idx_ff < count_ff)
      else $error("non-final response outside a view");

endmodule

[tb/sv/testbench.sv]
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = dwd_pkg::DepthDefault;
   localparam int DATA_W      = dwd_pkg::DATA_W;
   localparam int COUNT_W     = dwd_pkg::COUNT_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 2 * DEPTH + 16;
   localparam int PHASE_ITEMS = 80;
   localparam int RANDOM_ITEMS = 500;

   // Codes outside the defined operation set; the block answers them with an OK status and leaves the queue unchanged.
   localparam dwd_pkg::op_type OP_SPARE_A = 3'd6;
   localparam dwd_pkg::op_type OP_SPARE_B = 3'd7;

   typedef struct packed {
      dwd_pkg::op_type           op;
      logic signed [DATA_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  data;
      dwd_pkg::status_type       status;
      logic                      last;
      logic [COUNT_W-1:0]        count;
   } rsp_item_type;

   logic clock;
   logic reset;

   dwd_req_if req_ch ();
   dwd_rsp_if rsp_ch ();

   deque_with_decimate_top #(
      .DEPTH (DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Request items waiting to be driven, and the responses they will cause.
   req_item_type req_backlog [$];
   rsp_item_type predicted_rsp [$];

   // Shadow copy of the ring store.
   logic signed [DATA_W-1:0] ring_mem [DEPTH];
   int unsigned              ring_head = 0;
   int unsigned              ring_held = 0;

   int unsigned req_accepted = 0;
   int unsigned cycle_count = 0;
   int          failures = 0;

   // Idle and stall percentages for each traffic phase.
   int unsigned send_idle_pct [4] = '{0, 57, 0, 24};
   int unsigned recv_stall_pct [4] = '{0, 0, 57, 24};

   // Clock generation.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Applies one accepted request to the shadow queue and queues its responses.
   task automatic apply_deque_op(input dwd_pkg::op_type op,
                                 input logic signed [DATA_W-1:0] value);
      rsp_item_type r;
      int unsigned  kept;
      int unsigned  pos;
      r = '{data: '0, status: dwd_pkg::ST_OK, last: 1'b1, count: '0};
      case (op)
         dwd_pkg::OP_PUSH_FRONT, dwd_pkg::OP_PUSH_BACK: begin
            if (ring_held >= DEPTH) begin
               r.status = dwd_pkg::ST_FULL;
            end else begin
               if (op == dwd_pkg::OP_PUSH_FRONT) begin
                  ring_head = (ring_head + DEPTH - 1) % DEPTH;
                  ring_mem[ring_head] = value;
               end else begin
                  ring_mem[(ring_head + ring_held) % DEPTH] = value;
               end
               ring_held++;
            end
         end
         dwd_pkg::OP_VIEW_FWD, dwd_pkg::OP_VIEW_BWD: begin
            if (ring_held == 0) begin
               r.status = dwd_pkg::ST_EMPTY;
            end else begin
               // One response per held entry, in the requested direction.
               for (int i = 0; i < ring_held; i++) begin
                  pos = (op == dwd_pkg::OP_VIEW_FWD) ? i : ring_held - 1 - i;
                  r.data  = ring_mem[(ring_head + pos) % DEPTH];
                  r.last  = (i + 1 == ring_held);
                  r.count = COUNT_W'(ring_held);
                  predicted_rsp.push_back(r);
               end
               return;
            end
         end
         dwd_pkg::OP_DECIMATE: begin
            if (ring_held < 2) begin
               r.status = dwd_pkg::ST_FEW;
            end else begin
               // Keep the even positions, packed towards the front.
               kept = (ring_held + 1) / 2;
               for (int i = 1; i < kept; i++) begin
                  ring_mem[(ring_head + i) % DEPTH] = ring_mem[(ring_head + 2 * i) % DEPTH];
               end
               ring_held = kept;
            end
         end
         dwd_pkg::OP_CLEAR: begin
            ring_head = 0;
            ring_held = 0;
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(ring_held);
      predicted_rsp.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   task automatic add_req(input dwd_pkg::op_type op, input logic signed [DATA_W-1:0] value);
      req_backlog.push_back('{op: op, value: value});
   endtask

   // Push values lean towards the extremes now and then.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic dwd_pkg::op_type pick_push();
      return $urandom_range(1) ? dwd_pkg::OP_PUSH_BACK : dwd_pkg::OP_PUSH_FRONT;
   endfunction

   function automatic dwd_pkg::op_type pick_view();
      return $urandom_range(1) ? dwd_pkg::OP_VIEW_BWD : dwd_pkg::OP_VIEW_FWD;
   endfunction

   // Request driver: offers the next backlog item when the channel is free, with random idle gaps in some phases.
   always @(posedge clock) begin
      req_item_type item;
      int unsigned  phase;
      phase = (req_accepted / PHASE_ITEMS) % 4;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_deque_op(req_ch.op, req_ch.value);
            req_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct[phase]) begin
               item = req_backlog.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.op    <= item.op;
               req_ch.value <= item.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks every taken item against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      int unsigned  phase;
      phase = (req_accepted / PHASE_ITEMS) % 4;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected response item: data %0h status %0d last %0d count %0d",
                      rsp_ch.data, rsp_ch.status, rsp_ch.last, rsp_ch.count);
               failures++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("data", want.data, rsp_ch.data);
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_ch.status));
               check_field("last", DATA_W'(want.last), DATA_W'(rsp_ch.last));
               check_field("count", DATA_W'(want.count), DATA_W'(rsp_ch.count));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct[phase]);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[deque_with_decimate_top] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned n_random;
      int unsigned run_len;
      req_ch.valid = 1'b0;
      req_ch.op    = dwd_pkg::OP_PUSH_FRONT;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      reset        = 1'b1;
      foreach (ring_mem[i]) ring_mem[i] = '0;

      // Directed items: empty-queue cases, spare codes, extremes and small decimations.
      add_req(dwd_pkg::OP_VIEW_FWD, '0);
      add_req(dwd_pkg::OP_VIEW_BWD, '0);
      add_req(dwd_pkg::OP_DECIMATE, '0);
      add_req(dwd_pkg::OP_CLEAR, '0);
      add_req(OP_SPARE_A, 32'sh1234_5678);
      add_req(OP_SPARE_B, '1);
      add_req(dwd_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      add_req(dwd_pkg::OP_DECIMATE, '0);
      add_req(dwd_pkg::OP_PUSH_BACK, 32'sh8000_0000);
      add_req(dwd_pkg::OP_PUSH_FRONT, '0);
      add_req(dwd_pkg::OP_PUSH_BACK, '1);
      add_req(dwd_pkg::OP_VIEW_FWD, '0);
      add_req(dwd_pkg::OP_VIEW_BWD, '0);
      add_req(dwd_pkg::OP_DECIMATE, '0);
      add_req(dwd_pkg::OP_VIEW_FWD, '0);
      add_req(dwd_pkg::OP_PUSH_BACK, 32'sh5555_5555);
      add_req(dwd_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
      add_req(dwd_pkg::OP_DECIMATE, '0);
      add_req(dwd_pkg::OP_VIEW_BWD, '0);
      add_req(dwd_pkg::OP_CLEAR, '0);
      add_req(dwd_pkg::OP_VIEW_FWD, '0);

      // Random part built from short sequences; fill bursts drive the queue towards full.
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0, 1: begin
               run_len = $urandom_range(DEPTH + 4, DEPTH - 2);
               repeat (run_len) add_req(pick_push(), pick_value());
               n_random += run_len;
            end
            2: begin
               add_req(pick_view(), $urandom);
               n_random++;
            end
            3: begin
               add_req(dwd_pkg::OP_DECIMATE, $urandom);
               n_random++;
            end
            4: begin
               add_req(dwd_pkg::OP_CLEAR, $urandom);
               n_random++;
            end
            5, 6, 7, 8: begin
               run_len = $urandom_range(6, 1);
               repeat (run_len) add_req(pick_push(), pick_value());
               if ($urandom_range(1)) begin
                  add_req(dwd_pkg::OP_DECIMATE, $urandom);
                  n_random++;
               end
               add_req(pick_view(), $urandom);
               n_random += run_len + 1;
            end
            default: begin
               // Noise: any code at all, the spare ones included.
               add_req(dwd_pkg::op_type'($urandom_range(7)), $urandom);
               n_random++;
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is taken and every response has arrived.
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_ch.valid || predicted_rsp.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (predicted_rsp.size() != 0) begin
         $error("%0d predicted response items never arrived", predicted_rsp.size());
         failures++;
      end
      if (failures == 0) begin
         $display("[deque_with_decimate_top] OK");
      end else begin
         $display("[deque_with_decimate_top] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
sv/dwd_pkg.sv
sv/dwd_req_if.sv
sv/dwd_rsp_if.sv
sv/dwd_ram.sv
sv/deque_with_decimate_top.sv
tb/sv/testbench.sv
